@@ hw/rtl/dynamic_fixed_point_alu_unit_assert.svh @@
// ----------------------------------------------------------------------------
// dynamic fixed-point alu assertion macros
// shared concurrent assertion forms, clocked on clk and quiet during reset
// ----------------------------------------------------------------------------
`ifndef DYNAMIC_FIXED_POINT_ALU_UNIT_ASSERT_SVH
`define DYNAMIC_FIXED_POINT_ALU_UNIT_ASSERT_SVH

// same-cycle implication
`define DFP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DFP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/dfp_pkg.sv @@
// ----------------------------------------------------------------------------
// dfp_pkg
// shared types, codes and the rescale/saturate function of the fixed-point alu
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dfp_pkg;

	localparam int WORD_W = 32;
	localparam int PT_W   = 5;
	localparam int LEN_W  = 6;
	localparam int CMD_W  = 3;
	localparam int PROD_W = 2 * WORD_W;
	localparam int WIDE_W = PROD_W + 2;
	localparam int DIFF_W = 7;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD    = 3'd0,
		CMD_SUB    = 3'd1,
		CMD_MUL    = 3'd2,
		CMD_DIV    = 3'd3,
		CMD_REBASE = 3'd4,
		CMD_CMP    = 3'd5
	} dfp_cmd_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] val;
		logic                     sat;
	} dfp_resc_t;

	typedef struct packed {
		logic [CMD_W-1:0]         op;
		logic [PT_W-1:0]          rpt;
		logic [LEN_W-1:0]         rlen;
		logic signed [WORD_W-1:0] pre_val;
		logic                     sat;
		logic                     dz;
		logic                     eq;
		logic                     gt;
		logic                     lt;
		logic signed [PROD_W-1:0] prod;
		logic signed [DIFF_W-1:0] post_diff;
		logic                     post_en;
		logic                     qneg;
	} dfp_side_t;

	function automatic logic [LEN_W-1:0] dfp_eff_len(input logic [LEN_W-1:0] len,
		input logic [LEN_W-1:0] maxw);
		logic [LEN_W-1:0] l;
		l = len;
		if (len == '0)
			l = LEN_W'(1);
		else if (len > maxw)
			l = maxw;
		return l;
	endfunction

	// shift to a new binary point, rnd rounds half to even going down, clamp to p bits
	function automatic dfp_resc_t dfp_rescale(input logic signed [WIDE_W-1:0] v,
		input logic signed [DIFF_W-1:0] diff, input logic [LEN_W-1:0] p, input logic rnd);
		logic signed [WIDE_W-1:0] nv;
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		logic [WIDE_W-1:0]        mask;
		logic [WIDE_W-1:0]        rv;
		logic [WIDE_W-1:0]        mid;
		logic [LEN_W-1:0]         r;
		dfp_resc_t                res;
		mask = '0;
		rv   = '0;
		mid  = '0;
		r    = '0;
		if (!diff[DIFF_W-1]) begin
			nv = v <<< diff[LEN_W-1:0];
		end else begin
			r    = LEN_W'(-diff);
			nv   = v >>> r;
			mask = (WIDE_W'(1) << r) - WIDE_W'(1);
			rv   = WIDE_W'(v) & mask;
			mid  = WIDE_W'(1) << (r - LEN_W'(1));
			if (rnd && ((rv > mid) || ((rv == mid) && nv[0])))
				nv = nv + WIDE_W'(1);
		end
		hi = (WIDE_W'(1) <<< (p - LEN_W'(1))) - WIDE_W'(1);
		lo = -hi - WIDE_W'(1);
		res.sat = 1'b0;
		if (nv > hi) begin
			res.val = hi[WORD_W-1:0];
			res.sat = 1'b1;
		end else if (nv < lo) begin
			res.val = lo[WORD_W-1:0];
			res.sat = 1'b1;
		end else begin
			res.val = nv[WORD_W-1:0];
		end
		return res;
	endfunction

endpackage

@@ hw/rtl/dfp_prep.sv @@
// ----------------------------------------------------------------------------
// dfp_prep
// first stage: decode, add/sub, rebase, compare, multiply and divider setup
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfp_prep import dfp_pkg::*; #(
	parameter int MAX_WORD_BITS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [CMD_W-1:0]         cmd,
	input  logic signed [WORD_W-1:0] a_value,
	input  logic [PT_W-1:0]          a_point,
	input  logic [LEN_W-1:0]         a_length,
	input  logic signed [WORD_W-1:0] b_value,
	input  logic [PT_W-1:0]          b_point,
	input  logic [LEN_W-1:0]         b_length,
	input  logic [PT_W-1:0]          target_point,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [WORD_W-1:0]        out_num,
	output logic [WORD_W-1:0]        out_den,
	output dfp_side_t                out_side
);

	localparam logic [LEN_W-1:0] MAXW = LEN_W'(MAX_WORD_BITS);

	logic [LEN_W-1:0]         al, bl, xtra;
	logic signed [WIDE_W-1:0] av_w, bv_w, sum_w;
	logic signed [DIFF_W-1:0] d_ab, d_ta, d_xtra, d_mul;
	logic signed [DIFF_W-1:0] dlo_a, dlo_b, dhi_a, dhi_b;
	logic [PT_W-1:0]          pt_lo, pt_hi;
	logic signed [PT_W+2:0]   qbp;
	logic signed [PROD_W-1:0] prod;
	dfp_resc_t                y_r, s_r, reb_r, num_r;
	dfp_resc_t                xt_lo, yt_lo, xt_hi, yt_hi, xr_lo, yr_lo, xr_hi, yr_hi;
	logic signed [WORD_W-1:0] y_val;
	logic                     y_sat, eq_c, gt_c, lt_c, bz;
	dfp_side_t                side_c;
	logic [WORD_W-1:0]        num_c, den_c;

	logic                     v_s1;
	logic [WORD_W-1:0]        num_s1, den_s1;
	dfp_side_t                side_s1;

	always_comb begin
		al     = dfp_eff_len(a_length, MAXW);
		bl     = dfp_eff_len(b_length, MAXW);
		av_w   = WIDE_W'(a_value);
		bv_w   = WIDE_W'(b_value);
		d_ab   = $signed({2'b00, a_point}) - $signed({2'b00, b_point});
		d_ta   = $signed({2'b00, target_point}) - $signed({2'b00, a_point});
		d_mul  = -$signed({2'b00, b_point});
		xtra   = MAXW - al;
		d_xtra = $signed({1'b0, xtra});

		// add and subtract
		y_r   = dfp_rescale(bv_w, d_ab, MAXW, 1'b1);
		y_val = (a_point == b_point) ? b_value : y_r.val;
		y_sat = (a_point != b_point) && y_r.sat;
		if (cmd == CMD_SUB)
			sum_w = av_w - WIDE_W'(y_val);
		else
			sum_w = av_w + WIDE_W'(y_val);
		s_r = dfp_rescale(sum_w, '0, MAXW, 1'b0);

		// rebase
		reb_r = dfp_rescale(av_w, d_ta, al, 1'b1);

		// multiply
		prod = a_value * b_value;

		// divide setup
		bz    = (b_value == '0);
		num_r = dfp_rescale(av_w, d_xtra, MAXW, 1'b1);
		num_c = num_r.val[WORD_W-1] ? WORD_W'(-num_r.val) : WORD_W'(num_r.val);
		den_c = b_value[WORD_W-1] ? WORD_W'(-b_value) : WORD_W'(b_value);
		qbp   = $signed({3'b000, a_point}) - $signed({3'b000, b_point})
			+ $signed({2'b00, xtra});
		if (qbp[PT_W+2])
			qbp = '0;

		// compare
		pt_lo = (a_point < b_point) ? a_point : b_point;
		pt_hi = (a_point > b_point) ? a_point : b_point;
		dlo_a = $signed({2'b00, pt_lo}) - $signed({2'b00, a_point});
		dlo_b = $signed({2'b00, pt_lo}) - $signed({2'b00, b_point});
		dhi_a = $signed({2'b00, pt_hi}) - $signed({2'b00, a_point});
		dhi_b = $signed({2'b00, pt_hi}) - $signed({2'b00, b_point});
		xt_lo = dfp_rescale(av_w, dlo_a, al, 1'b0);
		yt_lo = dfp_rescale(bv_w, dlo_b, bl, 1'b0);
		xt_hi = dfp_rescale(av_w, dhi_a, al, 1'b0);
		yt_hi = dfp_rescale(bv_w, dhi_b, bl, 1'b0);
		xr_lo = dfp_rescale(av_w, dlo_a, al, 1'b1);
		yr_lo = dfp_rescale(bv_w, dlo_b, bl, 1'b1);
		xr_hi = dfp_rescale(av_w, dhi_a, al, 1'b1);
		yr_hi = dfp_rescale(bv_w, dhi_b, bl, 1'b1);
		eq_c  = (xt_lo.val == yt_lo.val) && (xt_hi.val == yt_hi.val);
		if (xr_lo.val == yr_lo.val) begin
			gt_c = $signed(xr_hi.val) > $signed(yr_hi.val);
			lt_c = $signed(xr_hi.val) < $signed(yr_hi.val);
		end else begin
			gt_c = $signed(xr_lo.val) > $signed(yr_lo.val);
			lt_c = $signed(xr_lo.val) < $signed(yr_lo.val);
		end

		side_c      = '0;
		side_c.op   = cmd;
		side_c.prod = prod;
		case (cmd)
			CMD_ADD, CMD_SUB: begin
				side_c.pre_val = s_r.val;
				side_c.sat     = y_sat | s_r.sat;
				side_c.rpt     = a_point;
				side_c.rlen    = MAXW;
			end
			CMD_MUL: begin
				side_c.rpt       = a_point;
				side_c.rlen      = al;
				side_c.post_diff = d_mul;
				side_c.post_en   = 1'b1;
			end
			CMD_DIV: begin
				side_c.rpt       = a_point;
				side_c.rlen      = al;
				side_c.dz        = bz;
				side_c.sat       = !bz && num_r.sat;
				side_c.post_en   = !bz;
				side_c.post_diff = DIFF_W'($signed({3'b000, a_point}) - qbp);
				side_c.qneg      = num_r.val[WORD_W-1] ^ b_value[WORD_W-1];
			end
			CMD_REBASE: begin
				side_c.pre_val = reb_r.val;
				side_c.sat     = reb_r.sat;
				side_c.rpt     = target_point;
				side_c.rlen    = al;
			end
			CMD_CMP: begin
				side_c.eq = eq_c;
				side_c.gt = gt_c;
				side_c.lt = lt_c;
			end
			default: begin
				side_c.op = cmd;
			end
		endcase
	end

	assign in_ready = !v_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			num_s1  <= num_c;
			den_s1  <= den_c;
			side_s1 <= side_c;
		end
	end

	assign out_valid = v_s1;
	assign out_num   = num_s1;
	assign out_den   = den_s1;
	assign out_side  = side_s1;

endmodule

@@ hw/rtl/dfp_div.sv @@
// ----------------------------------------------------------------------------
// dfp_div
// pipelined restoring divider, one quotient bit per stage, side data rides along
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfp_div import dfp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [WORD_W-1:0] in_num,
	input  logic [WORD_W-1:0] in_den,
	input  dfp_side_t         in_side,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [WORD_W-1:0] out_quo,
	output dfp_side_t         out_side
);

	localparam int N = WORD_W;

	logic              v_s    [0:N];
	logic [WORD_W-1:0] rem_s  [0:N];
	logic [WORD_W-1:0] quo_s  [0:N];
	logic [WORD_W-1:0] den_s  [0:N];
	dfp_side_t         side_s [0:N];
	logic              rdy    [1:N+1];

	assign v_s[0]    = in_valid;
	assign rem_s[0]  = '0;
	assign quo_s[0]  = in_num;
	assign den_s[0]  = in_den;
	assign side_s[0] = in_side;
	assign rdy[N+1]  = out_ready;
	assign in_ready  = rdy[1];

	for (genvar k = 1; k <= N; k++) begin : g_stage
		logic [WORD_W:0]   trial;
		logic              ge;
		logic [WORD_W-1:0] rem_nx;

		assign rdy[k]  = !v_s[k] || rdy[k+1];
		assign trial   = {rem_s[k-1], quo_s[k-1][WORD_W-1]};
		assign ge      = trial >= {1'b0, den_s[k-1]};
		assign rem_nx  = ge ? WORD_W'(trial - {1'b0, den_s[k-1]}) : trial[WORD_W-1:0];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && v_s[k-1]) begin
				rem_s[k]  <= rem_nx;
				quo_s[k]  <= {quo_s[k-1][WORD_W-2:0], ge};
				den_s[k]  <= den_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_valid = v_s[N];
	assign out_quo   = quo_s[N];
	assign out_side  = side_s[N];

endmodule

@@ hw/rtl/dfp_post.sv @@
// ----------------------------------------------------------------------------
// dfp_post
// final stage: rescale of product or quotient, result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfp_post import dfp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [WORD_W-1:0]        in_quo,
	input  dfp_side_t                in_side,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [WORD_W-1:0] result_value,
	output logic [PT_W-1:0]          result_point,
	output logic [LEN_W-1:0]         result_length,
	output logic                     saturated,
	output logic                     divide_by_zero,
	output logic                     equal_flag,
	output logic                     greater_flag,
	output logic                     less_flag
);

	logic signed [WIDE_W-1:0] q_w, v_w;
	dfp_resc_t                r;
	logic signed [WORD_W-1:0] val_c;
	logic                     sat_c;

	logic                     v_q;
	logic signed [WORD_W-1:0] val_q;
	logic [PT_W-1:0]          pt_q;
	logic [LEN_W-1:0]         len_q;
	logic                     sat_q, dz_q, eq_q, gt_q, lt_q;

	always_comb begin
		q_w = $signed({{(WIDE_W-WORD_W){1'b0}}, in_quo});
		if (in_side.qneg)
			q_w = -q_w;
		v_w   = (in_side.op == CMD_MUL) ? WIDE_W'(in_side.prod) : q_w;
		r     = dfp_rescale(v_w, in_side.post_diff, in_side.rlen, 1'b1);
		val_c = in_side.post_en ? r.val : in_side.pre_val;
		sat_c = in_side.sat | (in_side.post_en & r.sat);
	end

	assign in_ready = !v_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			val_q <= val_c;
			pt_q  <= in_side.rpt;
			len_q <= in_side.rlen;
			sat_q <= sat_c;
			dz_q  <= in_side.dz;
			eq_q  <= in_side.eq;
			gt_q  <= in_side.gt;
			lt_q  <= in_side.lt;
		end
	end

	assign out_valid      = v_q;
	assign result_value   = val_q;
	assign result_point   = pt_q;
	assign result_length  = len_q;
	assign saturated      = sat_q;
	assign divide_by_zero = dz_q;
	assign equal_flag     = eq_q;
	assign greater_flag   = gt_q;
	assign less_flag      = lt_q;

endmodule

@@ hw/rtl/dynamic_fixed_point_alu_unit.sv @@
// ----------------------------------------------------------------------------
// dynamic_fixed_point_alu_unit
// signed fixed-point add, subtract, multiply, divide, rebase and compare with
// per-operand binary point and word length, convergent rounding, saturation
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------
//   in       | in_valid / in_stall  | cmd, a_*, b_*, target_point
//   out      | out_valid / out_stall| result_value .. less_flag
//
// one item per cycle unless out_stall holds a full stage; stages: setup stage,
// 32 divider stages (one quotient bit each), final rescale stage
// every item takes the divider path so results leave in order
// stages hold on a downstream stall only when full, empty stages keep filling
// arst_n clears the valid bits only
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dynamic_fixed_point_alu_unit import dfp_pkg::*; #(
	parameter int MAX_WORD_BITS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [CMD_W-1:0]         cmd,
	input  logic signed [WORD_W-1:0] a_value,
	input  logic [PT_W-1:0]          a_point,
	input  logic [LEN_W-1:0]         a_length,
	input  logic signed [WORD_W-1:0] b_value,
	input  logic [PT_W-1:0]          b_point,
	input  logic [LEN_W-1:0]         b_length,
	input  logic [PT_W-1:0]          target_point,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [WORD_W-1:0] result_value,
	output logic [PT_W-1:0]          result_point,
	output logic [LEN_W-1:0]         result_length,
	output logic                     saturated,
	output logic                     divide_by_zero,
	output logic                     equal_flag,
	output logic                     greater_flag,
	output logic                     less_flag
);

`include "dynamic_fixed_point_alu_unit_assert.svh"

	logic              in_ready;
	logic              p_valid, p_ready, d_valid, d_ready;
	logic [WORD_W-1:0] p_num, p_den, d_quo;
	dfp_side_t         p_side, d_side;

	assign in_stall = !in_ready;

	dfp_prep #(
		.MAX_WORD_BITS(MAX_WORD_BITS)
	) u_prep (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.a_value      (a_value),
		.a_point      (a_point),
		.a_length     (a_length),
		.b_value      (b_value),
		.b_point      (b_point),
		.b_length     (b_length),
		.target_point (target_point),
		.out_valid    (p_valid),
		.out_ready    (p_ready),
		.out_num      (p_num),
		.out_den      (p_den),
		.out_side     (p_side)
	);

	dfp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (p_valid),
		.in_ready  (p_ready),
		.in_num    (p_num),
		.in_den    (p_den),
		.in_side   (p_side),
		.out_valid (d_valid),
		.out_ready (d_ready),
		.out_quo   (d_quo),
		.out_side  (d_side)
	);

	dfp_post u_post (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (d_valid),
		.in_ready       (d_ready),
		.in_quo         (d_quo),
		.in_side        (d_side),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_value   (result_value),
		.result_point   (result_point),
		.result_length  (result_length),
		.saturated      (saturated),
		.divide_by_zero (divide_by_zero),
		.equal_flag     (equal_flag),
		.greater_flag   (greater_flag),
		.less_flag      (less_flag)
	);

	`DFP_ASSERT_NOW(a_dz_zero, out_valid && divide_by_zero, result_value == '0 && !saturated, "divide by zero item carries a value")
	`DFP_ASSERT_NOW(a_cmp_excl, out_valid, !(greater_flag && less_flag), "greater and less both set")
	`DFP_ASSERT_NOW(a_dz_cmp, out_valid && divide_by_zero, !equal_flag && !greater_flag && !less_flag, "compare flags on a divide item")
	`DFP_ASSERT_NOW(a_no_stall_in, !out_valid, !in_stall, "input stalled with an empty output stage")
	`DFP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(result_value), "stalled item changed")

endmodule
